>>> rtl/cpit_pkg.sv
package cpit_pkg;

   // Request kinds.
   localparam logic [1:0] KIND_GET    = 2'd0;
   localparam logic [1:0] KIND_PUT    = 2'd1;
   localparam logic [1:0] KIND_REMOVE = 2'd2;

   // Result status codes.
   localparam logic [2:0] STATUS_REUSED    = 3'd0;
   localparam logic [2:0] STATUS_NEW       = 3'd1;
   localparam logic [2:0] STATUS_FULL      = 3'd2;
   localparam logic [2:0] STATUS_RESTAMPED = 3'd3;
   localparam logic [2:0] STATUS_REMOVED   = 3'd4;
   localparam logic [2:0] STATUS_INVALID   = 3'd5;

   // Configuration register indexes.
   localparam logic [7:0] CSR_IDLE_LIMIT     = 8'd0;
   localparam logic [7:0] CSR_SWEEP_INTERVAL = 8'd1;

   localparam logic [15:0] IDLE_LIMIT_RESET     = 16'd300;
   localparam logic [15:0] SWEEP_INTERVAL_RESET = 16'd60;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] addr_key;
      logic [15:0] port;
      logic [7:0]  conn_type;
      logic [5:0]  slot_index;
      logic [31:0] now_seconds;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  slot;
      logic [6:0]  occupied_count;
      logic [31:0] hit_count;
      logic [31:0] miss_count;
      logic [31:0] created_count;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] addr_key;
      logic [15:0] port;
      logic [7:0]  conn_type;
      logic [31:0] stamp;
   } entry_type;

   typedef struct packed {
      logic key_eq;
      logic stale;
      logic due;
   } cmp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRIME,
      ST_SCAN,
      ST_DUE,
      ST_SLOT_RD,
      ST_SLOT_CHK,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      PH_MATCH1,
      PH_SWEEP,
      PH_MATCH2,
      PH_ALLOC
   } phase_type;

endpackage

>>> rtl/cpit_mem.sv
module cpit_mem
   import cpit_pkg::*;
#(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  entry_type         wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output entry_type         rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/cpit_cmp.sv
module cpit_cmp
   import cpit_pkg::*;
(
   input  entry_type   entry,
   input  req_type     req,
   input  logic [31:0] ref_time,
   input  logic [15:0] idle_limit,
   input  logic [15:0] sweep_interval,
   output cmp_type     result
);

   logic [31:0] elapsed;

   // One wrapping subtractor serves both the idle test and the sweep interval test.
   assign elapsed = req.now_seconds - ref_time;

   assign result.key_eq = (entry.addr_key == req.addr_key) && (entry.port == req.port) &&
                          (entry.conn_type == req.conn_type);
   assign result.stale  = elapsed > {16'd0, idle_limit};
   assign result.due    = !(elapsed < {16'd0, sweep_interval});

endmodule

>>> rtl/connection_pool_idle_table_top.sv
// Keyed connection table with idle eviction. The slot records sit in one memory with a single
// read port, and a small sequencer walks it one slot per cycle through a shared compare unit.
// A get first scans the slots for a match. On a miss it scans for a free slot to allocate,
// or, on a full table, sweeps stale entries if the sweep interval is due and then runs a
// second match scan. Put and remove read the named slot, then check and update it; an
// unused kind code or a slot beyond the table goes straight to the result. The block takes
// one request at a time and holds req_ready low until the result word is in the output
// register; a finished word waits there while the next request is taken. Configuration
// writes are accepted in any cycle and must be issued only while the block is idle.
module connection_pool_idle_table_top
   import cpit_pkg::*;
#(
   parameter int POOL_ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int IDX_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
   localparam int CNT_W = $clog2(POOL_ENTRIES + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_ENTRIES - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(POOL_ENTRIES);

   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] hw_ff, hw_in;
   logic [CNT_W-1:0] occupied_ff, occupied_in;
   logic [31:0] hits_ff, hits_in;
   logic [31:0] misses_ff, misses_in;
   logic [31:0] created_ff, created_in;
   logic [31:0] last_sweep_ff, last_sweep_in;
   logic [15:0] idle_limit_ff, idle_limit_in;
   logic [15:0] interval_ff, interval_in;
   req_type     req_ff, req_in;
   logic [2:0]  status_ff, status_in;
   logic [5:0]  slot_ff, slot_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   logic [IDX_W-1:0] rd_addr;
   entry_type        rd_data;
   logic [31:0]      ref_time;
   cmp_type          cmp;

   logic [IDX_W-1:0] slot_addr;
   logic slot_in_range;
   logic slot_valid;
   logic ent_valid;
   logic ent_match;
   logic last_idx;
   logic in_match_phase;
   logic take_hit;
   logic take_free;
   logic drop_entry;
   logic rsp_free;

   cpit_mem #(
      .DEPTH  (POOL_ENTRIES),
      .ADDR_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cpit_cmp u_cmp (
      .entry          (rd_data),
      .req            (req_ff),
      .ref_time       (ref_time),
      .idle_limit     (idle_limit_ff),
      .sweep_interval (interval_ff),
      .result         (cmp)
   );

   // Slots at or above the high-water mark were never allocated, so they read as free.
   assign slot_addr      = IDX_W'(req_ff.slot_index);
   assign slot_in_range  = 32'(req_data.slot_index) < POOL_ENTRIES;
   assign slot_valid     = rd_data.valid && (CNT_W'(slot_addr) < hw_ff);
   assign ent_valid      = rd_data.valid && (CNT_W'(idx_ff) < hw_ff);
   assign ent_match      = ent_valid && cmp.key_eq;
   assign last_idx       = idx_ff == LAST_IDX;
   assign in_match_phase = (phase_ff == PH_MATCH1) || (phase_ff == PH_MATCH2);
   assign take_hit       = in_match_phase && ent_match && !cmp.stale;
   assign take_free      = (phase_ff == PH_ALLOC) && !ent_valid;
   assign drop_entry     = (in_match_phase && ent_match && cmp.stale) ||
                           ((phase_ff == PH_SWEEP) && ent_valid && cmp.stale);
   assign rsp_free       = !rsp_valid_ff || rsp_ready;
   assign ref_time       = (state_ff == ST_DUE) ? last_sweep_ff : rd_data.stamp;
   assign rd_addr        = (state_ff == ST_SLOT_RD) ? slot_addr : idx_in;

   assign req_ready = state_ff == ST_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_data.kind)
                  KIND_GET: begin
                     state_in = ST_PRIME;
                     phase_in = PH_MATCH1;
                  end
                  KIND_PUT, KIND_REMOVE: begin
                     state_in = slot_in_range ? ST_SLOT_RD : ST_RESP;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_PRIME: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            case (phase_ff)
               PH_MATCH1, PH_MATCH2: begin
                  if (take_hit) begin
                     state_in = ST_RESP;
                  end else if (last_idx) begin
                     state_in = (phase_ff == PH_MATCH1) ? ST_DUE : ST_RESP;
                  end
               end
               PH_SWEEP: begin
                  if (last_idx) begin
                     state_in = ST_PRIME;
                     phase_in = PH_MATCH2;
                  end
               end
               default: begin
                  if (take_free || last_idx) begin
                     state_in = ST_RESP;
                  end
               end
            endcase
         end
         ST_DUE: begin
            state_in = ST_PRIME;
            if (occupied_ff >= FULL_CNT) begin
               phase_in = cmp.due ? PH_SWEEP : PH_MATCH2;
            end else begin
               phase_in = PH_ALLOC;
            end
         end
         ST_SLOT_RD: begin
            state_in = ST_SLOT_CHK;
         end
         ST_SLOT_CHK: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      idx_in        = idx_ff;
      hw_in         = hw_ff;
      occupied_in   = occupied_ff;
      hits_in       = hits_ff;
      misses_in     = misses_ff;
      created_in    = created_ff;
      last_sweep_in = last_sweep_ff;
      idle_limit_in = idle_limit_ff;
      interval_in   = interval_ff;
      req_in        = req_ff;
      status_in     = status_ff;
      slot_in       = slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = rd_data;

      if (csr_valid) begin
         if (csr_index == CSR_IDLE_LIMIT) begin
            idle_limit_in = csr_data;
         end else if (csr_index == CSR_SWEEP_INTERVAL) begin
            interval_in = csr_data;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in    = req_data;
               status_in = STATUS_INVALID;
               slot_in   = req_data.slot_index;
            end
         end
         ST_PRIME: begin
            idx_in = '0;
         end
         ST_SCAN: begin
            // The read for the next slot goes out while this slot is checked.
            idx_in = last_idx ? '0 : idx_ff + 1'b1;
            if (drop_entry) begin
               wr_en         = 1'b1;
               wr_data.valid = 1'b0;
               if (occupied_ff != '0) begin
                  occupied_in = occupied_ff - 1'b1;
               end
            end
            if (take_hit) begin
               wr_en         = 1'b1;
               wr_data.stamp = req_ff.now_seconds;
               hits_in       = hits_ff + 32'd1;
               status_in     = STATUS_REUSED;
               slot_in       = 6'(idx_ff);
            end else if (in_match_phase && last_idx) begin
               misses_in = misses_ff + 32'd1;
               if (phase_ff == PH_MATCH2) begin
                  status_in = STATUS_FULL;
                  slot_in   = '0;
               end
            end
            if ((phase_ff == PH_SWEEP) && last_idx) begin
               last_sweep_in = req_ff.now_seconds;
            end
            if (take_free) begin
               wr_en             = 1'b1;
               wr_data.valid     = 1'b1;
               wr_data.addr_key  = req_ff.addr_key;
               wr_data.port      = req_ff.port;
               wr_data.conn_type = req_ff.conn_type;
               wr_data.stamp     = req_ff.now_seconds;
               occupied_in       = occupied_ff + 1'b1;
               created_in        = created_ff + 32'd1;
               if (CNT_W'(idx_ff) == hw_ff) begin
                  hw_in = hw_ff + 1'b1;
               end
               status_in = STATUS_NEW;
               slot_in   = 6'(idx_ff);
            end else if ((phase_ff == PH_ALLOC) && last_idx) begin
               status_in = STATUS_FULL;
               slot_in   = '0;
            end
         end
         ST_SLOT_CHK: begin
            wr_addr = slot_addr;
            if (slot_valid) begin
               wr_en = 1'b1;
               if (req_ff.kind == KIND_PUT) begin
                  wr_data.stamp = req_ff.now_seconds;
                  status_in     = STATUS_RESTAMPED;
               end else begin
                  wr_data.valid = 1'b0;
                  status_in     = STATUS_REMOVED;
                  if (occupied_ff != '0) begin
                     occupied_in = occupied_ff - 1'b1;
                  end
               end
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.status         = status_ff;
               rsp_data_in.slot           = slot_ff;
               rsp_data_in.occupied_count = 7'(occupied_ff);
               rsp_data_in.hit_count      = hits_ff;
               rsp_data_in.miss_count     = misses_ff;
               rsp_data_in.created_count  = created_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_MATCH1;
         idx_ff        <= '0;
         hw_ff         <= '0;
         occupied_ff   <= '0;
         hits_ff       <= '0;
         misses_ff     <= '0;
         created_ff    <= '0;
         last_sweep_ff <= '0;
         idle_limit_ff <= IDLE_LIMIT_RESET;
         interval_ff   <= SWEEP_INTERVAL_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         idx_ff        <= idx_in;
         hw_ff         <= hw_in;
         occupied_ff   <= occupied_in;
         hits_ff       <= hits_in;
         misses_ff     <= misses_in;
         created_ff    <= created_in;
         last_sweep_ff <= last_sweep_in;
         idle_limit_ff <= idle_limit_in;
         interval_ff   <= interval_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      status_ff   <= status_in;
      slot_ff     <= slot_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_occupied_bound: assert property (@(posedge clock) disable iff (reset)
      occupied_ff <= FULL_CNT)
      else $error("occupied count exceeds table size");

   a_occupied_below_mark: assert property (@(posedge clock) disable iff (reset)
      occupied_ff <= hw_ff)
      else $error("occupied count exceeds high-water mark");

   a_hits_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_SCAN) |=> $stable(hits_ff))
      else $error("hit counter changed outside a scan");

   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RESP) && rsp_free) |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("result word not loaded when output register was free");

endmodule
